// ----- design/bdr_pkg.sv -----
// ----------------------------------------------------------------------------
// bdr_pkg: shared types and constants for the button debounce and repeat bank
// Holds the configuration record, the per-lane event record, register
// indexes, counter widths and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bdr_pkg;

  // Number of sampled pins and width of every result mask.
  localparam int unsigned PinCount   = 8;
  localparam int unsigned DefButtons = 8;

  // Counter widths.
  localparam int unsigned CntW = 8;
  localparam int unsigned TotW = 16;
  localparam int unsigned SumW = 4;

  // Configuration port shape.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CfgDebounce    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRepeatStart = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRepeatLoad  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLongTicks   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLongEnable  = 3'd4;

  // Register reset values.
  localparam logic [CntW-1:0] DebounceRst    = 8'd5;
  localparam logic [CntW-1:0] RepeatStartRst = 8'd50;
  localparam logic [CntW-1:0] RepeatLoadRst  = 8'd25;
  localparam logic [TotW-1:0] LongTicksRst   = 16'd100;
  localparam logic            LongEnableRst  = 1'b1;

  // Saturation limits and state reset values.
  localparam logic [CntW-1:0] UpMax  = 8'hFF;
  localparam logic [TotW-1:0] TotMax = 16'hFFFF;

  // Configuration as seen by every lane.
  typedef struct packed {
    logic [CntW-1:0] debounce;
    logic [CntW-1:0] repeat_start;
    logic [CntW-1:0] repeat_load;
    logic [TotW-1:0] long_ticks;
    logic            long_enable;
  } cfg_t;

  // Events and held flag produced by one lane for the current tick.
  typedef struct packed {
    logic first;
    logic repeat_press;
    logic release_evt;
    logic long_press;
    logic held;
  } lane_evt_t;

  // One result item.
  typedef struct packed {
    logic [PinCount-1:0] first_mask;
    logic [PinCount-1:0] repeat_mask;
    logic [PinCount-1:0] release_mask;
    logic [PinCount-1:0] long_mask;
    logic [PinCount-1:0] held_mask;
    logic [SumW-1:0]     summary;
  } result_t;

endpackage : bdr_pkg

`default_nettype wire

// ----- design/bdr_lane.sv -----
// ----------------------------------------------------------------------------
// bdr_lane: state and tick logic of one button
// Keeps level history, up and down timers, total held time, repeat mark and
// debounced held flag, and works out this tick's events.
// ----------------------------------------------------------------------------
`default_nettype none

module bdr_lane (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  wire                  level_i,
  input  bdr_pkg::cfg_t        cfg_i,
  output bdr_pkg::lane_evt_t   evt_o
);
  import bdr_pkg::*;

  logic            prev_q, prev_d;
  logic [CntW-1:0] up_q, up_d;
  logic [CntW-1:0] dn_q, dn_d;
  logic [TotW-1:0] tot_q, tot_d;
  logic            mark_q, mark_d;
  logic            held_q, held_d;

  logic            press_start;
  logic            press_evt;
  logic            rel_evt;
  logic            long_evt;
  logic            tot_count;
  logic [CntW-1:0] up1;
  logic [CntW-1:0] dn1;
  logic [CntW-1:0] dn2;
  logic [TotW-1:0] tot1;
  logic [TotW-1:0] tot2;
  logic            mark1;

  // Tick update, following the order of the rules on one button.
  always_comb begin
    // A debounced release restarts the up timer.
    up1 = (level_i && !prev_q && (dn_q >= cfg_i.debounce)) ? '0 : up_q;

    // A new press after enough up time restarts the down timers.
    press_start = !level_i && prev_q && (up1 >= cfg_i.debounce);
    tot1  = (press_start && cfg_i.long_enable) ? '0 : tot_q;
    dn1   = press_start ? '0 : dn_q;
    mark1 = press_start ? 1'b0 : mark_q;

    // Press and release events.
    press_evt = !level_i && (dn1 == cfg_i.debounce) && (up1 >= cfg_i.debounce);
    rel_evt   = level_i && (up1 == cfg_i.debounce) && (dn1 >= cfg_i.debounce);

    held_d = held_q;
    if (press_evt) begin
      held_d = 1'b1;
    end
    if (rel_evt) begin
      held_d = 1'b0;
    end

    // Total held time and long press.
    tot_count = cfg_i.long_enable && !level_i && (tot1 < TotMax);
    tot2      = tot_count ? tot1 + TotW'(1) : tot1;
    long_evt  = tot_count && (tot2 == cfg_i.long_ticks);
    tot_d     = tot2;

    // Down timer with auto-repeat reload.
    dn2 = level_i ? dn1 : dn1 + CntW'(1);
    if (dn2 == cfg_i.repeat_start) begin
      dn_d   = cfg_i.repeat_load;
      mark_d = 1'b1;
    end else begin
      dn_d   = dn2;
      mark_d = mark1;
    end

    // Up timer saturates.
    up_d = (level_i && (up1 < UpMax)) ? up1 + CntW'(1) : up1;

    prev_d = level_i;
  end

  // Lane state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b1;
      up_q   <= UpMax;
      dn_q   <= '0;
      tot_q  <= '0;
      mark_q <= 1'b0;
      held_q <= 1'b0;
    end else if (step_i) begin
      prev_q <= prev_d;
      up_q   <= up_d;
      dn_q   <= dn_d;
      tot_q  <= tot_d;
      mark_q <= mark_d;
      held_q <= held_d;
    end
  end

  // The repeat mark in force at the press selects the event kind.
  assign evt_o.first        = press_evt && !mark1;
  assign evt_o.repeat_press = press_evt && mark1;
  assign evt_o.release_evt  = rel_evt;
  assign evt_o.long_press   = long_evt;
  assign evt_o.held         = held_d;

`ifndef SYNTHESIS
  // A press is either a first press or a repeat, never both.
  a_press_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(evt_o.first && evt_o.repeat_press))
    else $error("first and repeat press in the same tick");

  // Press and release cannot fire together.
  a_press_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((evt_o.first || evt_o.repeat_press) && evt_o.release_evt))
    else $error("press and release in the same tick");

  // Long press only fires while tracking is enabled.
  a_long_enable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.long_press |-> cfg_i.long_enable)
    else $error("long press while tracking is disabled");

  // A taken press leaves the button held.
  a_press_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (evt_o.first || evt_o.repeat_press)) |=> held_q)
    else $error("held flag not set after press");
`endif

endmodule : bdr_lane

`default_nettype wire

// ----- design/bdr_merge.sv -----
// ----------------------------------------------------------------------------
// bdr_merge: gathers lane events into result masks
// Builds the five per-pin masks and the summary nibble and holds them in the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdr_merge #(
  parameter int unsigned Buttons = bdr_pkg::DefButtons
) (
  input  wire                          clk_i,
  input  wire                          load_i,
  input  bdr_pkg::lane_evt_t [Buttons-1:0] evt_i,
  output bdr_pkg::result_t             result_o
);
  import bdr_pkg::*;

  logic [PinCount-1:0] first_w;
  logic [PinCount-1:0] repeat_w;
  logic [PinCount-1:0] release_w;
  logic [PinCount-1:0] long_w;
  logic [PinCount-1:0] held_w;
  result_t             result_d;
  result_t             result_q;

  // Only lanes wired to a pin contribute to the masks.
  for (genvar g = 0; g < PinCount; g++) begin : g_pin
    if (g < Buttons) begin : g_lane
      assign first_w[g]   = evt_i[g].first;
      assign repeat_w[g]  = evt_i[g].repeat_press;
      assign release_w[g] = evt_i[g].release_evt;
      assign long_w[g]    = evt_i[g].long_press;
      assign held_w[g]    = evt_i[g].held;
    end else begin : g_none
      assign first_w[g]   = 1'b0;
      assign repeat_w[g]  = 1'b0;
      assign release_w[g] = 1'b0;
      assign long_w[g]    = 1'b0;
      assign held_w[g]    = 1'b0;
    end
  end

  // Summary bits are the OR of each event mask.
  always_comb begin
    result_d.first_mask   = first_w;
    result_d.repeat_mask  = repeat_w;
    result_d.release_mask = release_w;
    result_d.long_mask    = long_w;
    result_d.held_mask    = held_w;
    result_d.summary      = {|long_w, |release_w, |repeat_w, |first_w};
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule : bdr_merge

`default_nettype wire

// ----- design/button_debounce_repeat.sv -----
// ----------------------------------------------------------------------------
// button_debounce_repeat: debounced button bank with auto repeat and long press
// Each request is one timer tick of active-low pin samples; each result gives
// press, repeat, release and long-press pulses, the held mask and a summary.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid_i/in_ready_o  | raw_levels_i
//   out     | output    | out_valid_o/out_ready_i| masks, held_mask_o, summary
//   cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One request per clock cycle when not stalled; its result appears in the
// output register on the next cycle. All lanes update together from their
// own counters. A new request is taken whenever the output register is empty
// or is being read in the same cycle. Reset acts at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_repeat #(
  parameter int unsigned BUTTONS = bdr_pkg::DefButtons
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire [bdr_pkg::PinCount-1:0]    raw_levels_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [bdr_pkg::PinCount-1:0]   first_press_mask_o,
  output logic [bdr_pkg::PinCount-1:0]   repeat_press_mask_o,
  output logic [bdr_pkg::PinCount-1:0]   release_mask_o,
  output logic [bdr_pkg::PinCount-1:0]   long_press_mask_o,
  output logic [bdr_pkg::PinCount-1:0]   held_mask_o,
  output logic [bdr_pkg::SumW-1:0]       event_summary_o,
  input  wire                            cfg_we_i,
  input  wire [bdr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire [bdr_pkg::CfgDataW-1:0]    cfg_data_i
);
  import bdr_pkg::*;

  cfg_t                     cfg_q;
  logic                     out_valid_q;
  logic                     accept;
  lane_evt_t [BUTTONS-1:0]  evt;
  result_t                  result;

  // Handshake: the output register frees up when it is read.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce     <= DebounceRst;
      cfg_q.repeat_start <= RepeatStartRst;
      cfg_q.repeat_load  <= RepeatLoadRst;
      cfg_q.long_ticks   <= LongTicksRst;
      cfg_q.long_enable  <= LongEnableRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDebounce:    cfg_q.debounce     <= cfg_data_i[CntW-1:0];
        CfgRepeatStart: cfg_q.repeat_start <= cfg_data_i[CntW-1:0];
        CfgRepeatLoad:  cfg_q.repeat_load  <= cfg_data_i[CntW-1:0];
        CfgLongTicks:   cfg_q.long_ticks   <= cfg_data_i[TotW-1:0];
        CfgLongEnable:  cfg_q.long_enable  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // One lane per button; buttons without a pin always read released.
  for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
    logic level;
    if (b < PinCount) begin : g_pin
      assign level = raw_levels_i[b];
    end else begin : g_nopin
      assign level = 1'b1;
    end

    bdr_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (accept),
      .level_i (level),
      .cfg_i   (cfg_q),
      .evt_o   (evt[b])
    );
  end

  // Merge lane events into the result register.
  bdr_merge #(
    .Buttons (BUTTONS)
  ) u_merge (
    .clk_i    (clk_i),
    .load_i   (accept),
    .evt_i    (evt),
    .result_o (result)
  );

  assign out_valid_o         = out_valid_q;
  assign first_press_mask_o  = result.first_mask;
  assign repeat_press_mask_o = result.repeat_mask;
  assign release_mask_o      = result.release_mask;
  assign long_press_mask_o   = result.long_mask;
  assign held_mask_o         = result.held_mask;
  assign event_summary_o     = result.summary;

endmodule : button_debounce_repeat

`default_nettype wire
